/* rtl/apsrf_pkg.sv */
package apsrf_pkg;

   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 136;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 40;

   // request kinds
   localparam logic [1:0] REQ_COORD   = 2'd0;
   localparam logic [1:0] REQ_ADJ     = 2'd1;
   localparam logic [1:0] REQ_COMPUTE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPRING_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPULSION_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT_AREA    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTROID_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTROID_Y     = 3'd4;

   // divider: partial remainder preset, low dividend bits shifted in MSB first
   typedef struct packed {
      logic        start;
      logic [63:0] rem_init;
      logic [55:0] low_bits;
      logic [5:0]  steps;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

endpackage

/* rtl/apsrf_div.sv */
module apsrf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  apsrf_pkg::div_req_type req,
   output apsrf_pkg::div_rsp_type rsp
);
   import apsrf_pkg::*;

   logic [64:0] rem_ff;
   logic [55:0] low_ff;
   logic [63:0] quot_ff;
   logic [63:0] div_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [64:0] rem_sh;
   logic        ge;

   always_comb begin
      rem_sh = {rem_ff[63:0], low_ff[55]};
      ge     = rem_sh >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= {1'b0, req.rem_init};
         low_ff  <= req.low_bits;
         quot_ff <= '0;
         div_ff  <= req.divisor;
      end else if (busy_ff) begin
         rem_ff  <= ge ? rem_sh - {1'b0, div_ff} : rem_sh;
         low_ff  <= {low_ff[54:0], 1'b0};
         quot_ff <= {quot_ff[62:0], ge};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

/* rtl/apsrf_sqrt.sv */
module apsrf_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  apsrf_pkg::sqrt_req_type req,
   output apsrf_pkg::sqrt_rsp_type rsp
);
   import apsrf_pkg::*;

   logic [63:0] val_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [34:0] rem_sh;
   logic [34:0] trial;
   logic        ge;

   // two radicand bits per step, one root bit out
   always_comb begin
      rem_sh = {rem_ff[32:0], val_ff[63:62]};
      trial  = {1'b0, root_ff, 2'b01};
      ge     = rem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         val_ff  <= req.radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[61:0], 2'b00};
         rem_ff  <= ge ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[30:0], ge};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

/* rtl/all_pairs_spring_repulsion_force.sv */
// channel | dir | tdata (low bit up)                                   | tuser    | tlast
// req_    | in  | vertex_index, neighbor_index, edge_present, coord_x,  | req_type | -
//         |     | coord_y, vertex_count, zero pad                       |          |
// rsp_    | out | vertex_index_res, force_x, force_y, coord_x_res,      | -        | last
//         |     | coord_y_res, zero pad                                 |          |
// csr_    | in  | csr_we, csr_index, csr_wdata (no read back)           |          |
//
// Coordinate writes keep req_tready high; adjacency writes do a row read-modify-write.
// Compute: the rest length first (56-step divide, 32-step root), then each vertex in turn;
// a pair costs a distance, a repulsion term and, with an edge, a spring term. The shared
// 1-bit/cycle divider and root unit carry the divides and square roots.
// Synchronous reset clears control, registers and the adjacency row valid bits.
// A stalled result holds the sequencer only when the next result is ready to go.
module all_pairs_spring_repulsion_force #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // vertex_index[5:0], neighbor_index[11:6], edge_present[12], coord_x[44:13],
   // coord_y[76:45], vertex_count[83:77], pad
   input  logic [apsrf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type[1:0]
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // vertex_index_res[5:0], force_x[37:6], force_y[69:38], coord_x_res[101:70],
   // coord_y_res[133:102], pad
   output logic [apsrf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [apsrf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [apsrf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import apsrf_pkg::*;

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam logic [6:0] MAXV = 7'(MAX_VERTICES);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_ADJ_RD  = 5'd1;
   localparam logic [4:0] S_ADJ_WR  = 5'd2;
   localparam logic [4:0] S_ONE     = 5'd3;
   localparam logic [4:0] S_LDIV    = 5'd4;
   localparam logic [4:0] S_LDIV_W  = 5'd5;
   localparam logic [4:0] S_LSQ_W   = 5'd6;
   localparam logic [4:0] S_ROW     = 5'd7;
   localparam logic [4:0] S_ROW_D   = 5'd8;
   localparam logic [4:0] S_PAIR    = 5'd9;
   localparam logic [4:0] S_DIFF    = 5'd10;
   localparam logic [4:0] S_SQX     = 5'd11;
   localparam logic [4:0] S_SQY     = 5'd12;
   localparam logic [4:0] S_SUM     = 5'd13;
   localparam logic [4:0] S_SQRT_W  = 5'd14;
   localparam logic [4:0] S_SPM     = 5'd15;
   localparam logic [4:0] S_SPM2    = 5'd16;
   localparam logic [4:0] S_CMUL    = 5'd17;
   localparam logic [4:0] S_CDIV    = 5'd18;
   localparam logic [4:0] S_CWAIT   = 5'd19;
   localparam logic [4:0] S_REP     = 5'd20;
   localparam logic [4:0] S_RWAIT   = 5'd21;
   localparam logic [4:0] S_EMIT    = 5'd22;

   // configuration
   logic [31:0] ka_ff, kr_ff, cent_x_ff, cent_y_ff;
   logic [39:0] area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ka_ff     <= '0;
         kr_ff     <= '0;
         area_ff   <= '0;
         cent_x_ff <= '0;
         cent_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPRING_GAIN:    ka_ff     <= csr_wdata[31:0];
            CSR_REPULSION_GAIN: kr_ff     <= csr_wdata[31:0];
            CSR_LAYOUT_AREA:    area_ff   <= csr_wdata;
            CSR_CENTROID_X:     cent_x_ff <= csr_wdata[31:0];
            CSR_CENTROID_Y:     cent_y_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic [5:0]  in_vi, in_ni;
   logic        in_ep;
   logic [31:0] in_cx, in_cy;
   logic [6:0]  in_vc, in_n;
   logic        req_acc;

   assign in_vi   = req_tdata[5:0];
   assign in_ni   = req_tdata[11:6];
   assign in_ep   = req_tdata[12];
   assign in_cx   = req_tdata[44:13];
   assign in_cy   = req_tdata[76:45];
   assign in_vc   = req_tdata[83:77];
   assign in_n    = (in_vc > MAXV) ? MAXV : in_vc;

   logic [4:0] state_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // storage
   logic [63:0]             pos_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adj_vld_ff;
   logic [63:0]             pos_rd_ff;
   logic [MAX_VERTICES-1:0] adj_rd_ff;
   logic                    adj_rv_ff;

   logic          pos_we;
   logic [AW-1:0] pos_waddr, pos_raddr, adj_raddr;
   logic [63:0]   pos_wdata;
   logic [MAX_VERTICES-1:0] adj_base, adj_mod;

   // sequencer registers
   logic [5:0]  vi_ff, ni_ff;
   logic        ep_ff;
   logic [6:0]  n_ff, i_ff, j_ff;
   logic [31:0] xi_ff, yi_ff, len_ff, d_ff, at_ff;
   logic [MAX_VERTICES-1:0] row_ff;
   logic [31:0] adx_ff, ady_ff;
   logic        dxneg_ff, dyneg_ff, tneg_ff;
   logic [63:0] sq_ff, s_ff;
   logic [30:0] mag_ff;
   logic        axis_ff, spring_ff;
   logic signed [39:0] accx_ff, accy_ff;
   logic [63:0] mul_p_ff;
   logic [31:0] mul_a, mul_b;

   logic        rsp_valid_ff, rsp_last_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic        out_free;
   logic        emit_fire;

   div_req_type  dreq;
   div_rsp_type  drsp;
   sqrt_req_type sreq;
   sqrt_rsp_type srsp;

   apsrf_div  u_div  (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));
   apsrf_sqrt u_sqrt (.clock(clock), .reset(reset), .req(sreq), .rsp(srsp));

   function automatic logic [31:0] sat40(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > 40'sh007FFFFFFF)       r = 32'h7FFFFFFF;
      else if (v < -40'sh0080000000) r = 32'h80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   // saturated coordinate difference
   logic [32:0] dfx, dfy;
   logic [31:0] dxs, dys;
   always_comb begin
      dfx = {pos_rd_ff[31], pos_rd_ff[31:0]} - {xi_ff[31], xi_ff};
      dfy = {pos_rd_ff[63], pos_rd_ff[63:32]} - {yi_ff[31], yi_ff};
      if (dfx[32] != dfx[31]) dxs = dfx[32] ? 32'h80000000 : 32'h7FFFFFFF;
      else                    dxs = dfx[31:0];
      if (dfy[32] != dfy[31]) dys = dfy[32] ? 32'h80000000 : 32'h7FFFFFFF;
      else                    dys = dfy[31:0];
   end

   logic [63:0] s_sum;
   logic [32:0] t_diff;
   logic [31:0] t_abs;
   logic        term_neg;
   logic [39:0] term;
   assign s_sum    = sq_ff + mul_p_ff;
   assign t_diff   = {1'b0, srsp.root} - {1'b0, len_ff};
   assign t_abs    = t_diff[32] ? 32'(-t_diff) : t_diff[31:0];
   assign term_neg = spring_ff ? ((axis_ff ? dyneg_ff : dxneg_ff) ^ tneg_ff)
                               : ~(axis_ff ? dyneg_ff : dxneg_ff);
   assign term     = {8'd0, drsp.quot[31:0]};
   assign out_free = !rsp_valid_ff || rsp_tready;
   // a new result is loaded this cycle
   assign emit_fire = (state_ff == S_EMIT || state_ff == S_ONE) && out_free;

   // shared multiplier, product registered
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQX:   begin mul_a = adx_ff; mul_b = adx_ff; end
         S_SQY:   begin mul_a = ady_ff; mul_b = ady_ff; end
         S_SPM:   begin mul_a = at_ff;  mul_b = ka_ff;  end
         S_CMUL:  begin mul_a = {1'b0, mag_ff}; mul_b = axis_ff ? ady_ff : adx_ff; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // divider and root requests
   always_comb begin
      dreq = '0;
      sreq = '0;
      unique case (state_ff)
         S_LDIV: begin
            dreq.start    = 1'b1;
            dreq.low_bits = {area_ff, 16'd0};
            dreq.steps    = 6'd56;
            dreq.divisor  = 64'({n_ff, 2'b00} + {2'b00, n_ff});
         end
         S_CDIV: begin
            dreq.start    = 1'b1;
            dreq.rem_init = {32'd0, mul_p_ff[62:31]};
            dreq.low_bits = {mul_p_ff[30:0], 25'd0};
            dreq.steps    = 6'd31;
            dreq.divisor  = {32'd0, d_ff};
         end
         S_REP: begin
            dreq.start    = ({kr_ff, 1'b0} < s_ff);
            dreq.rem_init = {31'd0, kr_ff, 1'b0};
            dreq.steps    = 6'd31;
            dreq.divisor  = s_ff;
         end
         S_LDIV_W: begin
            sreq.start    = drsp.done;
            sreq.radicand = drsp.quot;
         end
         S_SUM: begin
            sreq.start    = (s_sum != 64'd0);
            sreq.radicand = s_sum;
         end
         default: ;
      endcase
   end

   // memory ports
   always_comb begin
      pos_we    = 1'b0;
      pos_waddr = in_vi[AW-1:0];
      pos_wdata = {in_cy, in_cx};
      if (req_acc && req_tuser == REQ_COORD && {1'b0, in_vi} < MAXV) begin
         pos_we = 1'b1;
      end else if (req_acc && req_tuser == REQ_COMPUTE && in_n == 7'd1) begin
         pos_we    = 1'b1;
         pos_waddr = '0;
         pos_wdata = {cent_y_ff, cent_x_ff};
      end
      pos_raddr = (state_ff == S_ROW) ? i_ff[AW-1:0] : j_ff[AW-1:0];
      adj_raddr = (state_ff == S_ROW) ? i_ff[AW-1:0] : vi_ff[AW-1:0];
      adj_base  = adj_rv_ff ? adj_rd_ff : '0;
      adj_mod   = adj_base;
      adj_mod[ni_ff[AW-1:0]] = ep_ff;
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ADJ_WR) adj_mem[vi_ff[AW-1:0]] <= adj_mod;
      adj_rd_ff <= adj_mem[adj_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_vld_ff <= '0;
         adj_rv_ff  <= 1'b0;
      end else begin
         adj_rv_ff <= adj_vld_ff[adj_raddr];
         if (state_ff == S_ADJ_WR) adj_vld_ff[vi_ff[AW-1:0]] <= 1'b1;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !emit_fire) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  vi_ff <= in_vi;
                  ni_ff <= in_ni;
                  ep_ff <= in_ep;
                  n_ff  <= in_n;
                  if (req_tuser == REQ_ADJ && {1'b0, in_vi} < MAXV
                      && {1'b0, in_ni} < MAXV) begin
                     state_ff <= S_ADJ_RD;
                  end else if (req_tuser == REQ_COMPUTE && in_n == 7'd1) begin
                     state_ff <= S_ONE;
                  end else if (req_tuser == REQ_COMPUTE && in_n != 7'd0) begin
                     state_ff <= S_LDIV;
                  end
               end
            end
            S_ADJ_RD: state_ff <= S_ADJ_WR;
            S_ADJ_WR: state_ff <= S_IDLE;
            S_ONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  rsp_data_ff  <= {2'b00, cent_y_ff, cent_x_ff, 64'd0, 6'd0};
                  state_ff     <= S_IDLE;
               end
            end
            S_LDIV:   state_ff <= S_LDIV_W;
            S_LDIV_W: if (drsp.done) state_ff <= S_LSQ_W;
            S_LSQ_W: begin
               if (srsp.done) begin
                  len_ff   <= srsp.root;
                  i_ff     <= '0;
                  state_ff <= S_ROW;
               end
            end
            S_ROW: state_ff <= S_ROW_D;
            S_ROW_D: begin
               xi_ff    <= pos_rd_ff[31:0];
               yi_ff    <= pos_rd_ff[63:32];
               row_ff   <= adj_base;
               accx_ff  <= '0;
               accy_ff  <= '0;
               j_ff     <= '0;
               state_ff <= S_PAIR;
            end
            S_PAIR: begin
               if (j_ff == n_ff)      state_ff <= S_EMIT;
               else if (j_ff == i_ff) j_ff <= j_ff + 7'd1;
               else                   state_ff <= S_DIFF;
            end
            S_DIFF: begin
               dxneg_ff <= dxs[31];
               dyneg_ff <= dys[31];
               adx_ff   <= dxs[31] ? 32'(-dxs) : dxs;
               ady_ff   <= dys[31] ? 32'(-dys) : dys;
               state_ff <= S_SQX;
            end
            S_SQX: state_ff <= S_SQY;
            S_SQY: begin
               sq_ff    <= mul_p_ff;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               s_ff <= s_sum;
               // coincident vertices add nothing
               if (s_sum == 64'd0) begin
                  j_ff     <= j_ff + 7'd1;
                  state_ff <= S_PAIR;
               end else begin
                  state_ff <= S_SQRT_W;
               end
            end
            S_SQRT_W: begin
               if (srsp.done) begin
                  d_ff     <= srsp.root;
                  at_ff    <= t_abs;
                  tneg_ff  <= t_diff[32];
                  state_ff <= row_ff[j_ff[AW-1:0]] ? S_SPM : S_REP;
               end
            end
            S_SPM: state_ff <= S_SPM2;
            S_SPM2: begin
               mag_ff    <= (mul_p_ff[63:47] != '0) ? 31'h7FFFFFFF : mul_p_ff[46:16];
               axis_ff   <= 1'b0;
               spring_ff <= 1'b1;
               state_ff  <= S_CMUL;
            end
            S_CMUL: state_ff <= S_CDIV;
            S_CDIV: state_ff <= S_CWAIT;
            S_CWAIT: begin
               if (drsp.done) begin
                  if (axis_ff) accy_ff <= term_neg ? accy_ff - term : accy_ff + term;
                  else         accx_ff <= term_neg ? accx_ff - term : accx_ff + term;
                  if (!axis_ff) begin
                     axis_ff  <= 1'b1;
                     state_ff <= S_CMUL;
                  end else if (spring_ff) begin
                     state_ff <= S_REP;
                  end else begin
                     j_ff     <= j_ff + 7'd1;
                     state_ff <= S_PAIR;
                  end
               end
            end
            S_REP: begin
               axis_ff   <= 1'b0;
               spring_ff <= 1'b0;
               if ({kr_ff, 1'b0} >= s_ff) begin
                  mag_ff   <= 31'h7FFFFFFF;
                  state_ff <= S_CMUL;
               end else begin
                  state_ff <= S_RWAIT;
               end
            end
            S_RWAIT: begin
               if (drsp.done) begin
                  mag_ff   <= drsp.quot[30:0];
                  state_ff <= S_CMUL;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= (i_ff == n_ff - 7'd1);
                  rsp_data_ff  <= {2'b00, yi_ff, xi_ff, sat40(accy_ff), sat40(accx_ff),
                                   i_ff[5:0]};
                  i_ff         <= i_ff + 7'd1;
                  state_ff     <= (i_ff == n_ff - 7'd1) ? S_IDLE : S_ROW;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/apsrf_chk.sv */
module apsrf_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [apsrf_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [apsrf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);
   import apsrf_pkg::*;

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_coord_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser == REQ_COORD |=> req_tready)
      else $error("coordinate write did not return to ready");

   a_adj_rmw: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser == REQ_ADJ && req_tdata[5:0] == 6'd0 && req_tdata[11:6] == 6'd0
      |=> !req_tready)
      else $error("adjacency write skipped its row update");

   a_single_vertex: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser == REQ_COMPUTE && req_tdata[83:77] == 7'd1 && !rsp_tvalid
      |=> ##1 rsp_tvalid && rsp_tlast && rsp_tdata[69:0] == 70'd0)
      else $error("single vertex result missing or wrong");

endmodule

bind all_pairs_spring_repulsion_force apsrf_chk u_apsrf_chk (.*);

/* tb/sv/tb_all_pairs_spring_repulsion_force.sv */
`timescale 1ns / 1ps

module tb_all_pairs_spring_repulsion_force;
   import apsrf_pkg::*;

   localparam int CYCLE_LIMIT = 10000000;
   localparam int EXP_DEPTH   = 256;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [5:0]  vertex;
      logic [31:0] force_x;
      logic [31:0] force_y;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic        last;
   } force_rec_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // block state as the checker sees it
   longint unsigned ka, kr, area;
   logic [31:0]     cent_x, cent_y;
   logic [31:0]     pos_x [64];
   logic [31:0]     pos_y [64];
   logic [63:0]     adj_rows [64];
   bit              written [64];

   // expected results, ring buffer
   force_rec_type   expected_forces [EXP_DEPTH];
   int              exp_head = 0;
   int              exp_tail = 0;
   int              errors = 0;
   int              cycles = 0;
   int              burst_left = 0;
   int              hold_off = 0;

   all_pairs_spring_repulsion_force dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_all_pairs_spring_repulsion_force: done, errors");
         $finish;
      end
   end

   function automatic void stash_expected(force_rec_type rec);
      expected_forces[exp_tail % EXP_DEPTH] = rec;
      exp_tail++;
   endfunction

   // receiver: random stall patterns, plus a long hold-off on demand
   int rx_mode = 0;
   int rx_left = 0;
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready = 1'b0;
         hold_off--;
      end else begin
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 80);
         end
         rx_left--;
         case (rx_mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = ($urandom_range(0, 3) != 0);
            default: rsp_tready = $urandom_range(0, 1);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin : rsp_check
      force_rec_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[5:0], rsp_tdata[37:6], rsp_tdata[69:38], rsp_tdata[101:70],
                rsp_tdata[133:102], rsp_tlast};
         if (exp_tail == exp_head) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_forces[exp_head % EXP_DEPTH];
            exp_head++;
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch: exp v=%0d fx=%h fy=%h x=%h y=%h l=%b",
                     want.vertex, want.force_x, want.force_y, want.pos_x, want.pos_y,
                     want.last);
                  $display("          got v=%0d fx=%h fy=%h x=%h y=%h l=%b",
                     got.vertex, got.force_x, got.force_y, got.pos_x, got.pos_y,
                     got.last);
               end
            end
         end
      end
   end

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   // magnitude projected on one axis, truncated, sign of the component
   function automatic longint project(longint unsigned mag, longint comp,
                                      longint unsigned norm_d);
      longint unsigned a, q;
      a = comp < 0 ? longint'(-comp) : comp;
      q = (mag * a) / norm_d;
      return comp < 0 ? -longint'(q) : longint'(q);
   endfunction

   task automatic predict_forces(int count);
      longint unsigned rest, s, d, r, m, at;
      longint xi, yi, fx, fy, dx, dy, t, sx, sy;
      force_rec_type rec;
      if (count == 0) return;
      if (count > 64) count = 64;
      if (count == 1) begin
         pos_x[0] = cent_x;
         pos_y[0] = cent_y;
         written[0] = 1'b1;
         stash_expected('{6'd0, 32'd0, 32'd0, cent_x, cent_y, 1'b1});
         return;
      end
      rest = isqrt((area << 16) / (5 * count));
      for (int i = 0; i < count; i++) begin
         xi = longint'(signed'(pos_x[i]));
         yi = longint'(signed'(pos_y[i]));
         fx = 0;
         fy = 0;
         for (int j = 0; j < count; j++) begin
            if (j == i) continue;
            dx = clamp32(longint'(signed'(pos_x[j])) - xi);
            dy = clamp32(longint'(signed'(pos_y[j])) - yi);
            s = longint'(dx * dx) + longint'(dy * dy);
            if (s == 0) continue;   // coincident
            d = isqrt(s);
            if (adj_rows[i][j]) begin
               t = longint'(d) - longint'(rest);
               at = t < 0 ? longint'(-t) : t;
               m = (at * ka) >> 16;
               if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
               sx = project(m, dx, d);
               sy = project(m, dy, d);
               if (t < 0) begin
                  sx = -sx;
                  sy = -sy;
               end
               fx += sx;
               fy += sy;
            end
            r = (kr << 32) / s;
            if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
            fx -= project(r, dx, d);
            fy -= project(r, dy, d);
         end
         rec.vertex  = 6'(i);
         rec.force_x = 32'(clamp32(fx));
         rec.force_y = 32'(clamp32(fy));
         rec.pos_x   = pos_x[i];
         rec.pos_y   = pos_y[i];
         rec.last    = (i == count - 1);
         stash_expected(rec);
      end
   endtask

   task automatic send_req(logic [1:0] kind, logic [5:0] vi, logic [5:0] ni, logic ep,
                           logic [31:0] cx, logic [31:0] cy, logic [6:0] count);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {4'b0, count, cy, cx, ep, ni, vi};
      #1;
      while (!req_tready) begin
         @(negedge clock);
         #1;
      end
      @(posedge clock);
      burst_left--;
      case (kind)
         REQ_COORD: begin
            pos_x[vi] = cx;
            pos_y[vi] = cy;
            written[vi] = 1'b1;
         end
         REQ_ADJ: adj_rows[vi][ni] = ep;
         REQ_COMPUTE: predict_forces(int'(count));
         default: ;
      endcase
   endtask

   task automatic put_coord(int vi, logic [31:0] cx, logic [31:0] cy);
      send_req(REQ_COORD, 6'(vi), 6'($urandom), 1'($urandom), cx, cy, 7'($urandom));
   endtask

   task automatic put_edge(int vi, int ni, logic ep);
      send_req(REQ_ADJ, 6'(vi), 6'(ni), ep, $urandom, $urandom, 7'($urandom));
   endtask

   task automatic run_compute(int count);
      send_req(REQ_COMPUTE, 6'($urandom), 6'($urandom), 1'($urandom), $urandom, $urandom,
               7'(count));
   endtask

   task automatic send_unused();
      send_req(REQ_UNUSED, 6'($urandom), 6'($urandom), 1'($urandom), $urandom, $urandom,
               7'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (exp_tail != exp_head) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, longint unsigned val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = 40'(val);
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SPRING_GAIN:    ka = val & 64'hFFFF_FFFF;
         CSR_REPULSION_GAIN: kr = val & 64'hFFFF_FFFF;
         CSR_LAYOUT_AREA:    area = val & 64'hFF_FFFF_FFFF;
         CSR_CENTROID_X:     cent_x = 32'(val);
         CSR_CENTROID_Y:     cent_y = 32'(val);
         default: ;
      endcase
   endtask

   task automatic set_gains(longint unsigned a, longint unsigned b, longint unsigned c,
                            logic [31:0] x, logic [31:0] y);
      write_csr(CSR_SPRING_GAIN, a);
      write_csr(CSR_REPULSION_GAIN, b);
      write_csr(CSR_LAYOUT_AREA, c);
      write_csr(CSR_CENTROID_X, x);
      write_csr(CSR_CENTROID_Y, y);
   endtask

   function automatic int written_prefix();
      int k = 0;
      while (k < 64 && written[k]) k++;
      return k;
   endfunction

   task automatic test_directed();
      set_gains(32'h0001_0000, 32'h0004_0000, 40'h64_0000_0000, 32'h0003_8000, 32'hFFFE_0000);
      put_coord(0, 32'h0000_0000, 32'h0000_0000);
      put_coord(1, 32'h7FFF_FFFF, 32'h8000_0000);
      put_coord(2, 32'h8000_0000, 32'h7FFF_FFFF);
      put_coord(3, 32'h8000_0000, 32'h7FFF_FFFF);   // coincides with vertex 2
      put_coord(4, 32'h0001_0000, 32'h0002_0000);
      put_coord(5, 32'hFFFF_0000, 32'h0000_8000);
      put_coord(6, 32'h0000_0001, 32'hFFFF_FFFF);
      put_coord(7, 32'h0010_0000, 32'hFFF0_0000);
      put_edge(0, 1, 1'b1);
      put_edge(1, 0, 1'b1);
      put_edge(0, 0, 1'b1);                          // self-loop, no effect
      put_edge(4, 5, 1'b1);
      put_edge(2, 3, 1'b1);
      put_edge(4, 7, 1'b1);
      put_edge(4, 7, 1'b0);                          // clear again
      put_edge(63, 63, 1'b1);
      send_req(REQ_UNUSED, 6'h3F, 6'h3F, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
      run_compute(0);
      run_compute(2);
      run_compute(8);
      run_compute(1);
      drain();
   endtask

   task automatic test_config_extremes();
      longint unsigned settings [3][3] = '{
         '{0, 0, 0},
         '{64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFF_FFFF_FFFF},
         '{64'h0000_8000, 64'h0100_0000, 64'h0000_0001}
      };
      for (int k = 0; k < 3; k++) begin
         set_gains(settings[k][0], settings[k][1], settings[k][2],
                   k == 1 ? 32'h7FFF_FFFF : 32'h8000_0000, $urandom);
         run_compute(8);
         run_compute(1);
         put_coord(0, $urandom, $urandom);
         drain();
      end
   endtask

   task automatic test_random_traffic();
      int pick, top, vi;
      set_gains($urandom_range(0, 32'h0004_0000), $urandom, {$urandom, $urandom} & 40'hFF_FFFF_FFFF,
                $urandom, $urandom);
      for (int k = 0; k < 8; k++) begin
         pick = $urandom_range(0, 99);
         vi = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 9);
         if (pick < 35) begin
            put_coord(vi, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h00FF_FFFF)
                      - 32'h0080_0000, $urandom);
         end else if (pick < 60) begin
            put_edge(vi, $urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
                     : $urandom_range(0, 9), 1'($urandom));
         end else if (pick < 64) begin
            send_unused();
         end else begin
            top = written_prefix();
            if (top > 8) top = 8;
            run_compute($urandom_range(0, top));
         end
      end
      drain();
   endtask

   task automatic test_output_backpressure();
      hold_off = 6000;
      run_compute(8);
      for (int k = 0; k < 6; k++) put_coord($urandom_range(0, 7), $urandom, $urandom);
      run_compute(6);
      run_compute(1);
      drain();
   endtask

   task automatic test_full_size();
      set_gains(32'h0000_4000, 32'h0010_0000, 40'h00_4000_0000, $urandom, $urandom);
      // vertices 0..7 already hold coordinates
      for (int v = 8; v < 64; v++)
         put_coord(v, $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000,
                   $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000);
      for (int k = 0; k < 8; k++) put_edge($urandom_range(0, 63), $urandom_range(0, 63), 1'b1);
      run_compute(100);   // above the maximum, clipped to 64
      drain();
   endtask

   initial begin
      ka = 0;
      kr = 0;
      area = 0;
      cent_x = '0;
      cent_y = '0;
      for (int v = 0; v < 64; v++) begin
         pos_x[v] = '0;
         pos_y[v] = '0;
         adj_rows[v] = '0;
         written[v] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_config_extremes();
      test_random_traffic();
      test_output_backpressure();
      test_full_size();

      if (errors == 0) begin
         $display("tb_all_pairs_spring_repulsion_force: done, clean");
      end else begin
         $display("tb_all_pairs_spring_repulsion_force: done, errors");
      end
      $finish;
   end

endmodule
